[rtl/usmt_pkg.sv]
// usmt_pkg: constants, codes and helpers for the ultrasound sector mask block
// no dependencies; imported by ultrasound_sector_mask_test_top and tb_top
package usmt_pkg;

    localparam int PIXEL_COORD_BITS = 12;
    localparam int SPACING_W        = 16;
    localparam int PROD_W           = PIXEL_COORD_BITS + SPACING_W;
    localparam int POS_W            = 24;               // signed Q12.12 position
    localparam int POS_MAG_W        = POS_W - 1;        // clamped position magnitude
    localparam int DIFF_W           = POS_W + 1;        // offset from beam centre
    localparam int MAG_W            = POS_W;            // |offset|
    localparam int SQ_W             = 2 * MAG_W;
    localparam int DSQ_W            = SQ_W + 1;
    localparam int COS_W            = 16;
    localparam int COS_SQ_W         = 2 * COS_W - 1;
    localparam int DSQ_LO_W         = 25;
    localparam int DSQ_HI_W         = DSQ_W - DSQ_LO_W;
    localparam int PLO_W            = DSQ_LO_W + COS_SQ_W;
    localparam int PHI_W            = DSQ_HI_W + COS_SQ_W;
    localparam int ANG_W            = DSQ_W + COS_SQ_W;
    localparam int ANG_SHIFT        = 30;
    localparam int MODE_W           = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 48;

    localparam logic [POS_MAG_W-1:0] POS_MAX = {POS_MAG_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECTOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COS_HALF    = 3'd7;

    // clamp a pixel-times-spacing product to the largest positive position
    function automatic logic [POS_MAG_W-1:0] sat_pos(input logic [PROD_W-1:0] p);
        logic [POS_MAG_W-1:0] r;
        if (p > PROD_W'(POS_MAX))
            r = POS_MAX;
        else
            r = p[POS_MAG_W-1:0];
        return r;
    endfunction

    // magnitude of an offset; never exceeds MAG_W bits
    function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] a;
        a = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return a[MAG_W-1:0];
    endfunction

endpackage

[rtl/ultrasound_sector_mask_test_top.sv]
// ultrasound_sector_mask_test_top: per-pixel beam area mask, six-stage pipeline
// depends on usmt_pkg (constants, mode and register codes, clamp and magnitude)
//
// One pixel is taken in every clock cycle (busy stays low) and its mask bit appears on
// inside_beam with done high once the pixel has passed the six register stages:
// spacing multiply, clamp/centre/clip, squaring, distance sum, depth test with the
// split cosine products, and the final angle compare. Results cannot be held off.
// Configuration writes (cfg_ready is always high) must only be made with no pixel in
// flight; the derived squares follow in the next cycle.
module ultrasound_sector_mask_test_top
    import usmt_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
    input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
    output logic                        done,
    output logic                        inside_beam,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    // configuration
    logic [MODE_W-1:0]      mode_reg;
    logic [2*SPACING_W-1:0] spacing_reg;
    logic [2*POS_W-1:0]     center_reg;
    logic [2*POS_W-1:0]     clip_x_reg;
    logic [2*POS_W-1:0]     clip_y_reg;
    logic [2*POS_W-1:0]     depth_reg;
    logic [POS_W-1:0]       half_width_reg;
    logic [COS_W-1:0]       cos_reg;

    // derived from configuration
    logic [SQ_W-1:0]        start_sq_reg;
    logic [SQ_W-1:0]        end_sq_reg;
    logic [COS_SQ_W-1:0]    cos_sq_reg;
    logic [COS_W-1:0]       cos_mag;

    logic signed [POS_W-1:0] cx, cy, xmin, xmax, ymin, ymax;
    logic signed [COS_W-1:0] cos_s;
    logic [POS_W-1:0]        dstart, dend;

    // stage registers
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [PROD_W-1:0]        prodx_reg, prody_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic                     clip2_reg, clip3_reg, clip4_reg, clip5_reg;
    logic [SQ_W-1:0]          adx2_reg, ady2_3_reg, ady2_4_reg, ady2_5_reg;
    logic                     zero3_reg, zero4_reg, zero5_reg;
    logic                     dypos3_reg, dypos4_reg, dypos5_reg;
    logic                     dynn3_reg, dynn4_reg, dynn5_reg;
    logic                     lin3_reg, lin4_reg, lin5_reg;
    logic [DSQ_W-1:0]         dsq_reg;
    logic                     depth5_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic [PHI_W-1:0]         phi_reg;
    logic                     done_reg, inside_reg;

    // combinational
    logic                     accept;
    logic [POS_MAG_W-1:0]     px, py;
    logic signed [POS_W-1:0]  px_s, py_s;
    logic signed [DIFF_W-1:0] dx_next, dy_next;
    logic                     clip_next;
    logic [MAG_W-1:0]         adx, ady;
    logic                     lin_next;
    logic [DSQ_W-1:0]         dsq_next;
    logic [ANG_W-1:0]         rhs, lhs;
    logic                     ge, le, ang_ok, sector_ok, inside_next;

    assign accept    = start && !busy;
    assign busy      = 1'b0;         // fully pipelined, never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NONE;
            spacing_reg    <= '0;
            center_reg     <= '0;
            clip_x_reg     <= '0;
            clip_y_reg     <= '0;
            depth_reg      <= '0;
            half_width_reg <= '0;
            cos_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROBE_MODE:  mode_reg       <= cfg_data[MODE_W-1:0];
                REG_SPACING:     spacing_reg    <= cfg_data[2*SPACING_W-1:0];
                REG_BEAM_CENTER: center_reg     <= cfg_data[2*POS_W-1:0];
                REG_CLIP_X:      clip_x_reg     <= cfg_data[2*POS_W-1:0];
                REG_CLIP_Y:      clip_y_reg     <= cfg_data[2*POS_W-1:0];
                REG_DEPTH:       depth_reg      <= cfg_data[2*POS_W-1:0];
                REG_HALF_WIDTH:  half_width_reg <= cfg_data[POS_W-1:0];
                REG_COS_HALF:    cos_reg        <= cfg_data[COS_W-1:0];
                default:         mode_reg       <= mode_reg;
            endcase
        end
    end

    assign cx     = $signed(center_reg[POS_W-1:0]);
    assign cy     = $signed(center_reg[2*POS_W-1:POS_W]);
    assign xmin   = $signed(clip_x_reg[POS_W-1:0]);
    assign xmax   = $signed(clip_x_reg[2*POS_W-1:POS_W]);
    assign ymin   = $signed(clip_y_reg[POS_W-1:0]);
    assign ymax   = $signed(clip_y_reg[2*POS_W-1:POS_W]);
    assign dstart = depth_reg[POS_W-1:0];
    assign dend   = depth_reg[2*POS_W-1:POS_W];
    assign cos_s  = $signed(cos_reg);
    assign cos_mag = cos_reg[COS_W-1] ? COS_W'(-cos_reg) : cos_reg;

    // squared bounds, settled long before any item reaches the depth stage
    always_ff @(posedge clk)
    begin
        start_sq_reg <= SQ_W'(dstart) * SQ_W'(dstart);
        end_sq_reg   <= SQ_W'(dend) * SQ_W'(dend);
        cos_sq_reg   <= COS_SQ_W'(cos_mag) * COS_SQ_W'(cos_mag);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            v5_reg     <= v4_reg;
            done_reg   <= v5_reg;
            inside_reg <= inside_next;
        end
    end

    // stage 1: pixel index times spacing
    always_ff @(posedge clk)
    begin
        prodx_reg <= PROD_W'(pixel_x) * PROD_W'(spacing_reg[SPACING_W-1:0]);
        prody_reg <= PROD_W'(pixel_y) * PROD_W'(spacing_reg[2*SPACING_W-1:SPACING_W]);
    end

    // stage 2: clamp, offset from beam centre, clip rectangle
    assign px        = sat_pos(prodx_reg);
    assign py        = sat_pos(prody_reg);
    assign px_s      = $signed({1'b0, px});
    assign py_s      = $signed({1'b0, py});
    assign dx_next   = DIFF_W'(px_s) - DIFF_W'(cx);
    assign dy_next   = DIFF_W'(py_s) - DIFF_W'(cy);
    assign clip_next = (px_s >= xmin) && (px_s <= xmax) && (py_s >= ymin) && (py_s <= ymax);

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        clip2_reg <= clip_next;
    end

    // stage 3: magnitudes squared, linear probe test, sign flags
    assign adx      = mag(dx_reg);
    assign ady      = mag(dy_reg);
    assign lin_next = (adx <= half_width_reg)
                      && (dy_reg >= $signed({1'b0, dstart}))
                      && (dy_reg <= $signed({1'b0, dend}));

    always_ff @(posedge clk)
    begin
        adx2_reg   <= adx * adx;
        ady2_3_reg <= ady * ady;
        zero3_reg  <= (dx_reg == '0) && (dy_reg == '0);
        dypos3_reg <= (dy_reg > 0);
        dynn3_reg  <= !dy_reg[DIFF_W-1];
        lin3_reg   <= lin_next;
        clip3_reg  <= clip2_reg;
    end

    // stage 4: squared distance
    assign dsq_next = DSQ_W'(adx2_reg) + DSQ_W'(ady2_3_reg);

    always_ff @(posedge clk)
    begin
        dsq_reg    <= dsq_next;
        ady2_4_reg <= ady2_3_reg;
        zero4_reg  <= zero3_reg;
        dypos4_reg <= dypos3_reg;
        dynn4_reg  <= dynn3_reg;
        lin4_reg   <= lin3_reg;
        clip4_reg  <= clip3_reg;
    end

    // stage 5: depth bounds, distance times cosine squared in two halves
    always_ff @(posedge clk)
    begin
        depth5_reg <= (dsq_reg >= DSQ_W'(start_sq_reg)) && (dsq_reg <= DSQ_W'(end_sq_reg));
        plo_reg    <= dsq_reg[DSQ_LO_W-1:0] * cos_sq_reg;
        phi_reg    <= dsq_reg[DSQ_W-1:DSQ_LO_W] * cos_sq_reg;
        ady2_5_reg <= ady2_4_reg;
        zero5_reg  <= zero4_reg;
        dypos5_reg <= dypos4_reg;
        dynn5_reg  <= dynn4_reg;
        lin5_reg   <= lin4_reg;
        clip5_reg  <= clip4_reg;
    end

    // stage 6: angle compare dy^2 * 2^30 against |d|^2 * cos^2, mode select
    assign rhs = (ANG_W'(phi_reg) << DSQ_LO_W) + ANG_W'(plo_reg);
    assign lhs = ANG_W'(ady2_5_reg) << ANG_SHIFT;
    assign ge  = (lhs >= rhs);
    assign le  = (lhs <= rhs);

    always_comb
    begin
        if (zero5_reg)
            ang_ok = (cos_s <= 0);        // zero offset counts as off axis
        else if (cos_s > 0)
            ang_ok = dypos5_reg && ge;
        else
            ang_ok = dynn5_reg || le;
        sector_ok = ang_ok && depth5_reg;
        case (mode_reg)
            MODE_SECTOR: inside_next = v5_reg && clip5_reg && sector_ok;
            MODE_LINEAR: inside_next = v5_reg && clip5_reg && lin5_reg;
            default:     inside_next = 1'b0;
        endcase
    end

    assign done        = done_reg;
    assign inside_beam = inside_reg;

    // every accepted item comes out as a done strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("item accepted but no result six cycles later");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 6))
        else $error("result without a matching item");

    // a pixel outside the clip rectangle never reports inside
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !clip2_reg) |-> ##4 !inside_beam)
        else $error("clipped pixel reported inside the beam");

    assert property (@(posedge clk) disable iff (!rst_n)
        inside_beam |-> done)
        else $error("mask bit set without a result strobe");

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for the ultrasound sector mask block
// depends on usmt_pkg and ultrasound_sector_mask_test_top; predicts each mask bit in the bench
module tb_top;
    import usmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam longint POS_LIMIT    = 64'h7F_FFFF;
    localparam int     LIMIT_CYCLES = 200000;
    localparam int     ITEMS_PER_PHASE = 46;
    localparam int     RANDOM_PHASES   = 12;

    typedef struct {
        logic [PIXEL_COORD_BITS-1:0] col;
        logic [PIXEL_COORD_BITS-1:0] row;
    } pixel_t;

    typedef struct {
        logic [PIXEL_COORD_BITS-1:0] col;
        logic [PIXEL_COORD_BITS-1:0] row;
        logic                        in_beam;
    } mask_check_t;

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [31:0]         spacing;
        logic [47:0]         centre;
        logic [47:0]         clip_x;
        logic [47:0]         clip_y;
        logic [47:0]         depth;
        logic [23:0]         half_width;
        logic signed [15:0]  cos_half;
    } beam_settings_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [PIXEL_COORD_BITS-1:0] pixel_x;
    logic [PIXEL_COORD_BITS-1:0] pixel_y;
    logic                        done;
    logic                        inside_beam;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    beam_settings_t cur;
    pixel_t         pixels_to_send[$];
    mask_check_t    expected_masks[$];
    pixel_t         next_pixel;
    mask_check_t    taken_pixel;
    mask_check_t    oldest_mask;
    int unsigned    gap_left;
    int unsigned    idle_pct;
    int unsigned    mismatch_count;
    int unsigned    cycle_count;

    // pixel index times spacing, clamped to the largest positive position
    function automatic longint clamped_position(input logic [PIXEL_COORD_BITS-1:0] idx,
                                                input logic [15:0] pitch);
        longint prod;
        prod = longint'(idx) * longint'(pitch);
        return (prod > POS_LIMIT) ? POS_LIMIT : prod;
    endfunction

    function automatic logic predict_inside_beam(input logic [PIXEL_COORD_BITS-1:0] col,
                                                 input logic [PIXEL_COORD_BITS-1:0] row);
        longint px, py, dx, dy, adx, ady, dstart, dend, cosv;
        longint dsq;
        logic [127:0] lhs, rhs;
        logic ang_ok;
        px = clamped_position(col, cur.spacing[15:0]);
        py = clamped_position(row, cur.spacing[31:16]);
        dx = px - longint'($signed(cur.centre[23:0]));
        dy = py - longint'($signed(cur.centre[47:24]));
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        dstart = longint'(cur.depth[23:0]);
        dend = longint'(cur.depth[47:24]);
        if (px < longint'($signed(cur.clip_x[23:0])) || px > longint'($signed(cur.clip_x[47:24]))
            || py < longint'($signed(cur.clip_y[23:0]))
            || py > longint'($signed(cur.clip_y[47:24])))
            return 1'b0;
        case (cur.mode)
            MODE_SECTOR:
            begin
                dsq = adx * adx + ady * ady;
                cosv = longint'(cur.cos_half);
                // dy^2 scaled by the square of q1.15 one against |d|^2 cos^2
                lhs = {64'd0, ady * ady} << 30;
                rhs = {64'd0, dsq} * {64'd0, cosv * cosv};
                if (dx == 0 && dy == 0)
                    ang_ok = (cosv <= 0);
                else if (cosv > 0)
                    ang_ok = (dy > 0) && (lhs >= rhs);
                else
                    ang_ok = (dy >= 0) || (lhs <= rhs);
                return ang_ok && dsq >= dstart * dstart && dsq <= dend * dend;
            end
            MODE_LINEAR:
                return adx <= longint'(cur.half_width) && dy >= dstart && dy <= dend;
            default:
                return 1'b0;
        endcase
    endfunction

    // called at a rising edge; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PROBE_MODE:  cur.mode       = data[MODE_W-1:0];
            REG_SPACING:     cur.spacing    = data[31:0];
            REG_BEAM_CENTER: cur.centre     = data[47:0];
            REG_CLIP_X:      cur.clip_x     = data[47:0];
            REG_CLIP_Y:      cur.clip_y     = data[47:0];
            REG_DEPTH:       cur.depth      = data[47:0];
            REG_HALF_WIDTH:  cur.half_width = data[23:0];
            REG_COS_HALF:    cur.cos_half   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pixels_to_send.size() != 0 || expected_masks.size() != 0 || start)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [MODE_W-1:0] mode, input logic [31:0] spacing,
                                 input logic [47:0] centre, input logic [47:0] clip_x,
                                 input logic [47:0] clip_y, input logic [47:0] depth,
                                 input logic [23:0] half_width, input logic [15:0] cos_half);
        wait_idle();
        write_reg(REG_PROBE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_SPACING, CFG_DATA_W'(spacing));
        write_reg(REG_BEAM_CENTER, centre);
        write_reg(REG_CLIP_X, clip_x);
        write_reg(REG_CLIP_Y, clip_y);
        write_reg(REG_DEPTH, depth);
        write_reg(REG_HALF_WIDTH, CFG_DATA_W'(half_width));
        write_reg(REG_COS_HALF, CFG_DATA_W'(cos_half));
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input int unsigned col, input int unsigned row);
        pixel_t p;
        p.col = col[PIXEL_COORD_BITS-1:0];
        p.row = row[PIXEL_COORD_BITS-1:0];
        pixels_to_send.push_back(p);
    endtask

    ultrasound_sector_mask_test_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .done        (done),
        .inside_beam (inside_beam),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pixel driver: one item per accepted start, random gaps between items
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            taken_pixel.col = pixel_x;
            taken_pixel.row = pixel_y;
            taken_pixel.in_beam = predict_inside_beam(pixel_x, pixel_y);
            expected_masks.push_back(taken_pixel);
        end
        if (!(start && busy))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pixels_to_send.size() != 0)
            begin
                next_pixel = pixels_to_send.pop_front();
                start   <= 1'b1;
                pixel_x <= next_pixel.col;
                pixel_y <= next_pixel.row;
                if ($urandom_range(0, 99) >= idle_pct)
                    gap_left = 0;
                else if ($urandom_range(0, 9) < 8)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(8, 40);
            end
            else
                start <= 1'b0;
        end
    end

    // mask monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_masks.size() == 0)
            begin
                $display("%0t: result with nothing pending, inside_beam=%b", $time, inside_beam);
                mismatch_count++;
            end
            else
            begin
                oldest_mask = expected_masks.pop_front();
                if (inside_beam !== oldest_mask.in_beam)
                begin
                    $display("%0t: pixel (%0d,%0d) inside_beam expected %b actual %b", $time,
                             oldest_mask.col, oldest_mask.row, oldest_mask.in_beam, inside_beam);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL ultrasound_sector_mask_test_top");
            $finish;
        end
    end

    initial
    begin
        logic [MODE_W-1:0] mode;
        logic [15:0]       sx, sy;
        logic [15:0]       cosv;
        longint            ex, ey, cx, cy, xmin, xmax, ymin, ymax, dstart, dend, hw;
        int unsigned       window, roll;
        bit                wild;

        rst_n          = 1'b0;
        start          = 1'b0;
        pixel_x        = '0;
        pixel_y        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        gap_left       = 0;
        idle_pct       = 30;
        mismatch_count = 0;
        cycle_count    = 0;
        cur            = '{default: '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: mode none
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);

        // sector with apex above the image, 0.25 mm pixels
        load_settings(MODE_SECTOR, 32'h0400_0400, {24'hFF0000, 24'h080000},
                      {24'h100000, 24'h000000}, {24'h100000, 24'h000000},
                      {24'h0C8000, 24'h010000}, 24'h000000, 16'h5A82);
        queue_pixel(512, 400);
        queue_pixel(512, 0);      // exactly on the near depth bound
        queue_pixel(0, 100);      // outside the opening angle
        queue_pixel(4095, 4095);  // outside the clip rectangle

        // centre on a pixel: zero offset, straight down and straight up per cosine
        load_settings(MODE_SECTOR, 32'h0400_0400, {24'h064000, 24'h080000},
                      {24'h100000, 24'h000000}, {24'h100000, 24'h000000},
                      {24'h0C8000, 24'h000000}, 24'h000000, 16'h7FFF);
        queue_pixel(512, 400);
        queue_pixel(512, 800);
        queue_pixel(512, 0);
        load_settings(MODE_SECTOR, 32'h0400_0400, {24'h064000, 24'h080000},
                      {24'h100000, 24'h000000}, {24'h100000, 24'h000000},
                      {24'h0C8000, 24'h000000}, 24'h000000, 16'h0000);
        queue_pixel(512, 400);
        queue_pixel(512, 800);
        queue_pixel(512, 0);
        load_settings(MODE_SECTOR, 32'h0400_0400, {24'h064000, 24'h080000},
                      {24'h100000, 24'h000000}, {24'h100000, 24'h000000},
                      {24'h0C8000, 24'h000000}, 24'h000000, 16'h8000);
        queue_pixel(512, 400);
        queue_pixel(512, 800);
        queue_pixel(512, 0);

        // widest spacing: positions saturate, all bounds at their extremes
        load_settings(MODE_LINEAR, 32'hFFFF_FFFF, 48'h0, {24'h7FFFFF, 24'h800000},
                      {24'h7FFFFF, 24'h800000}, {24'hFFFFFF, 24'h000000}, 24'hFFFFFF, 16'h8000);
        queue_pixel(4095, 4095);
        queue_pixel(0, 0);
        queue_pixel(1, 4095);

        // linear edges at 1 mm pixels
        load_settings(MODE_LINEAR, 32'h1000_1000, {24'h000000, 24'h064000},
                      {24'h0C8000, 24'h000000}, {24'h0C8000, 24'h000000},
                      {24'h032000, 24'h00A000}, 24'h014000, 16'h0000);
        queue_pixel(120, 10);
        queue_pixel(121, 10);
        queue_pixel(80, 50);
        queue_pixel(80, 51);
        queue_pixel(100, 9);

        // empty clip rectangle, inverted depth bounds, unused mode code
        load_settings(MODE_LINEAR, 32'h1000_1000, {24'h000000, 24'h064000},
                      {24'h000000, 24'h0C8000}, {24'h0C8000, 24'h000000},
                      {24'h032000, 24'h00A000}, 24'h014000, 16'h0000);
        queue_pixel(100, 20);
        load_settings(MODE_LINEAR, 32'h1000_1000, {24'h000000, 24'h064000},
                      {24'h0C8000, 24'h000000}, {24'h0C8000, 24'h000000},
                      {24'h00A000, 24'h032000}, 24'h014000, 16'h0000);
        queue_pixel(100, 20);
        load_settings(MODE_UNUSED, 32'h1000_1000, {24'h000000, 24'h064000},
                      {24'h0C8000, 24'h000000}, {24'h0C8000, 24'h000000},
                      {24'h032000, 24'h00A000}, 24'h014000, 16'h0000);
        queue_pixel(100, 20);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wild = (ph == 3 || ph == 8);
            idle_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 50);
            if (wild)
            begin
                window = 4095;
                load_settings(MODE_W'($urandom_range(0, 3)), $urandom,
                              48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                              48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                              24'($urandom), 16'($urandom));
            end
            else
            begin
                // plausible probe geometry laid over a window of the image
                sx = 16'($urandom_range(16'h0100, 16'h1000));
                sy = ($urandom_range(0, 9) < 6) ? sx : 16'($urandom_range(16'h0100, 16'h1000));
                window = $urandom_range(63, 1023);
                ex = longint'(window) * longint'(sx);
                ey = longint'(window) * longint'(sy);
                cx = ex * 3 / 8 + longint'($urandom_range(0, 32'(ex / 4)));
                cy = longint'($urandom_range(0, 32'(ey / 4))) - ey / 8;
                xmin = longint'($urandom_range(0, 32'(ex / 8))) - ex / 16;
                xmax = ex - longint'($urandom_range(0, 32'(ex / 8)));
                ymin = longint'($urandom_range(0, 32'(ey / 8))) - ey / 16;
                ymax = ey - longint'($urandom_range(0, 32'(ey / 8)));
                dstart = longint'($urandom_range(0, 32'(ey / 4)));
                dend = longint'($urandom_range(32'(ey / 2), 32'(ey + ey / 4)));
                hw = longint'($urandom_range(32'(ex / 8), 32'(ex / 2)));
                cosv = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(8000, 32000))
                                                  : 16'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    mode = MODE_SECTOR;
                else if (roll < 85)
                    mode = MODE_LINEAR;
                else if (roll < 93)
                    mode = MODE_NONE;
                else
                    mode = MODE_UNUSED;
                load_settings(mode, {sy, sx}, {24'(cy), 24'(cx)}, {24'(xmax), 24'(xmin)},
                              {24'(ymax), 24'(ymin)}, {24'(dend), 24'(dstart)},
                              24'(hw), cosv);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // a fifth of the pixels anywhere in the image
                if ($urandom_range(0, 4) == 0)
                    queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                else
                    queue_pixel($urandom_range(0, window), $urandom_range(0, window));
            end
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS ultrasound_sector_mask_test_top");
        else
            $display("FAIL ultrasound_sector_mask_test_top");
        $finish;
    end

endmodule
